@@ sv/sdsf_pkg.sv @@
`default_nettype none

package sdsf_pkg;

    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 16;

    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

    // Register indexes on the configuration channel
    localparam cfg_idx_t REG_DEADZONE_ENABLE = 8'd0;
    localparam cfg_idx_t REG_CLAMP_ZONE      = 8'd1;
    localparam cfg_idx_t REG_DEADBAND        = 8'd2;
    localparam cfg_idx_t REG_MAX_WAIT_MS     = 8'd3;

    localparam logic        RST_DEADZONE_ENABLE = 1'b1;
    localparam logic [14:0] RST_CLAMP_ZONE      = 15'd7864;
    localparam logic [14:0] RST_DEADBAND        = 15'd6000;
    localparam logic [15:0] RST_MAX_WAIT_MS     = 16'd500;

    localparam logic [15:0] Q15_MAX = 16'h7FFF;

    typedef struct packed {
        logic signed [15:0] stick_x;
        logic signed [15:0] stick_y;
        logic               connected;
        logic [31:0]        now_ms;
    } in_beat_t;

    typedef struct packed {
        logic               send;
        logic signed [15:0] frac_x;
        logic signed [15:0] frac_y;
    } out_beat_t;

    // Per-axis divide setup: which side of the deadband, dividend and divisor
    typedef struct packed {
        logic        pos;
        logic        neg;
        logic [15:0] diff;
        logic [15:0] den;
    } axis_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_DIV_X,
        ST_FIN_X,
        ST_DIV_Y,
        ST_FIN_Y,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic take_in;
        logic prep;
        logic div_step;
        logic axis_y;
        logic fin;
        logic emit;
    } cmd_t;

    typedef struct packed {
        logic conn;
        logic div_last;
        logic out_free;
    } sts_t;

endpackage

`default_nettype wire

@@ sv/stick_deadband_send_filter_unit.sv @@
`default_nettype none

// Stick dead zone, Q15 rescale and send-on-change filter. One sample beat in
// gives one result beat out. A connected sample goes from accept to the next
// accept through capture, setup, 16 divider steps and a finish step per axis,
// then the send decision; a disconnected sample skips the divider. Both axes
// share the single radix-2 restoring divider in turn. A new sample is taken
// only once the last result sits in the output register, so a stalled
// result holds the block only in its send state. Config writes are taken in
// any cycle, and must only be issued while no sample is in flight.

module stick_deadband_send_filter_unit (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_valid,
    output logic                                 s_ready,
    input  wire sdsf_pkg::in_beat_t              s_data,
    output logic                                 m_valid,
    input  wire logic                            m_ready,
    output sdsf_pkg::out_beat_t                  m_data,
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [sdsf_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [sdsf_pkg::CFG_DATA_W-1:0] cfg_data
);

    sdsf_pkg::cmd_t cmd;
    sdsf_pkg::sts_t sts;

    sdsf_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    sdsf_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .sts       (sts),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

endmodule

`default_nettype wire

@@ sv/sdsf_ctrl.sv @@
`default_nettype none

module sdsf_ctrl (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            s_valid,
    output logic                 s_ready,
    input  wire sdsf_pkg::sts_t  sts,
    output sdsf_pkg::cmd_t       cmd
);

    sdsf_pkg::state_t state_reg;
    sdsf_pkg::state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= sdsf_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            sdsf_pkg::ST_IDLE: begin
                if (s_valid) state_next = sdsf_pkg::ST_PREP;
            end
            sdsf_pkg::ST_PREP: begin
                // disconnected samples skip the divider
                state_next = sts.conn ? sdsf_pkg::ST_DIV_X : sdsf_pkg::ST_EMIT;
            end
            sdsf_pkg::ST_DIV_X: begin
                if (sts.div_last) state_next = sdsf_pkg::ST_FIN_X;
            end
            sdsf_pkg::ST_FIN_X: begin
                state_next = sdsf_pkg::ST_DIV_Y;
            end
            sdsf_pkg::ST_DIV_Y: begin
                if (sts.div_last) state_next = sdsf_pkg::ST_FIN_Y;
            end
            sdsf_pkg::ST_FIN_Y: begin
                state_next = sdsf_pkg::ST_EMIT;
            end
            sdsf_pkg::ST_EMIT: begin
                if (sts.out_free) state_next = sdsf_pkg::ST_IDLE;
            end
            default: begin
                state_next = sdsf_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        cmd     = '0;
        s_ready = 1'b0;
        case (state_reg)
            sdsf_pkg::ST_IDLE: begin
                s_ready     = 1'b1;
                cmd.take_in = s_valid;
            end
            sdsf_pkg::ST_PREP: begin
                cmd.prep = 1'b1;
            end
            sdsf_pkg::ST_DIV_X: begin
                cmd.div_step = 1'b1;
            end
            sdsf_pkg::ST_FIN_X: begin
                cmd.fin = 1'b1;
            end
            sdsf_pkg::ST_DIV_Y: begin
                cmd.div_step = 1'b1;
                cmd.axis_y   = 1'b1;
            end
            sdsf_pkg::ST_FIN_Y: begin
                cmd.fin    = 1'b1;
                cmd.axis_y = 1'b1;
            end
            sdsf_pkg::ST_EMIT: begin
                cmd.emit = sts.out_free;
            end
            default: begin
                cmd = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

@@ sv/sdsf_dp.sv @@
`default_nettype none

module sdsf_dp (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire sdsf_pkg::cmd_t                cmd,
    output sdsf_pkg::sts_t                     sts,
    input  wire sdsf_pkg::in_beat_t            s_data,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output sdsf_pkg::out_beat_t                m_data,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [sdsf_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [sdsf_pkg::CFG_DATA_W-1:0] cfg_data
);

    function automatic sdsf_pkg::axis_t axis_prep(logic signed [15:0] v, logic [14:0] db);
        logic signed [16:0] vw;
        logic signed [16:0] dbw;
        sdsf_pkg::axis_t    a;
        vw     = {v[15], v};
        dbw    = {2'b00, db};
        a.pos  = vw > dbw;
        a.neg  = vw < -dbw;
        a.diff = a.pos ? 16'(vw - dbw) : 16'(-dbw - vw);
        a.den  = a.pos ? 16'(17'sd32767 - dbw) : 16'(17'sd32768 - dbw);
        return a;
    endfunction

    // configuration
    logic        dz_en_reg;
    logic [14:0] clamp_reg;
    logic [14:0] db_reg;
    logic [15:0] maxw_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dz_en_reg <= sdsf_pkg::RST_DEADZONE_ENABLE;
            clamp_reg <= sdsf_pkg::RST_CLAMP_ZONE;
            db_reg    <= sdsf_pkg::RST_DEADBAND;
            maxw_reg  <= sdsf_pkg::RST_MAX_WAIT_MS;
        end else if (cfg_valid) begin
            case (cfg_index)
                sdsf_pkg::REG_DEADZONE_ENABLE: dz_en_reg <= cfg_data[0];
                sdsf_pkg::REG_CLAMP_ZONE:      clamp_reg <= cfg_data[14:0];
                sdsf_pkg::REG_DEADBAND:        db_reg    <= cfg_data[14:0];
                sdsf_pkg::REG_MAX_WAIT_MS:     maxw_reg  <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // input capture and per-axis setup
    sdsf_pkg::in_beat_t in_reg;
    sdsf_pkg::axis_t    ax_reg;
    sdsf_pkg::axis_t    ay_reg;

    logic [15:0]        mag_x;
    logic [15:0]        mag_y;
    logic               clamp;
    logic signed [15:0] xc;
    logic signed [15:0] yc;

    always_comb begin
        mag_x = in_reg.stick_x[15] ? 16'(-in_reg.stick_x) : in_reg.stick_x;
        mag_y = in_reg.stick_y[15] ? 16'(-in_reg.stick_y) : in_reg.stick_y;
        clamp = dz_en_reg && (mag_x <= {1'b0, clamp_reg}) && (mag_y <= {1'b0, clamp_reg});
        xc    = clamp ? 16'sd0 : in_reg.stick_x;
        yc    = clamp ? 16'sd0 : in_reg.stick_y;
    end

    always_ff @(posedge aclk) begin
        if (cmd.take_in) in_reg <= s_data;
        if (cmd.prep) begin
            ax_reg <= axis_prep(xc, db_reg);
            ay_reg <= axis_prep(yc, db_reg);
        end
    end

    // shared restoring divider, one quotient bit per cycle; the first step
    // compares the unshifted difference since the quotient is at most 32768
    sdsf_pkg::axis_t sel;
    logic [3:0]      cnt_reg;
    logic [15:0]     rem_reg;
    logic [15:0]     rem_next;
    logic [15:0]     quo_reg;
    logic [16:0]     trial;
    logic [16:0]     sub;
    logic            ge;

    always_comb begin
        sel      = cmd.axis_y ? ay_reg : ax_reg;
        trial    = (cnt_reg == 4'd0) ? {1'b0, sel.diff} : {rem_reg, 1'b0};
        sub      = trial - {1'b0, sel.den};
        ge       = trial >= {1'b0, sel.den};
        rem_next = ge ? sub[15:0] : trial[15:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= 4'd0;
        end else if (cmd.div_step) begin
            cnt_reg <= cnt_reg + 4'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.div_step) begin
            rem_reg <= rem_next;
            quo_reg <= {quo_reg[14:0], ge};
        end
    end

    // quotient to Q15: saturate above, negate below
    logic [15:0] frac;
    logic [15:0] fx_reg;
    logic [15:0] fy_reg;

    always_comb begin
        if (sel.pos) begin
            frac = quo_reg[15] ? sdsf_pkg::Q15_MAX : quo_reg;
        end else if (sel.neg) begin
            frac = 16'(-quo_reg);
        end else begin
            frac = 16'd0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.fin) begin
            if (cmd.axis_y) fy_reg <= frac;
            else            fx_reg <= frac;
        end
    end

    // send decision and history
    logic [15:0] last_x_reg;
    logic [15:0] last_y_reg;
    logic [31:0] last_time_reg;
    logic [31:0] elapsed;
    logic        send;

    always_comb begin
        elapsed = in_reg.now_ms - last_time_reg;
        send    = in_reg.connected &&
                  ((elapsed > {16'd0, maxw_reg}) ||
                   (fx_reg != last_x_reg) || (fy_reg != last_y_reg));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_x_reg    <= 16'd0;
            last_y_reg    <= 16'd0;
            last_time_reg <= 32'd0;
        end else if (cmd.emit && send) begin
            last_x_reg    <= fx_reg;
            last_y_reg    <= fy_reg;
            last_time_reg <= in_reg.now_ms;
        end
    end

    // output register
    logic                m_valid_reg;
    sdsf_pkg::out_beat_t m_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.emit) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            m_data_reg.send   <= send;
            m_data_reg.frac_x <= in_reg.connected ? fx_reg : 16'd0;
            m_data_reg.frac_y <= in_reg.connected ? fy_reg : 16'd0;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    assign sts.conn     = in_reg.connected;
    assign sts.div_last = (cnt_reg == 4'hF);
    assign sts.out_free = !m_valid_reg || m_ready;

endmodule

`default_nettype wire

@@ sim/sdsf_checker.sv @@
module sdsf_checker
    import sdsf_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    input  logic                  s_ready,
    input  in_beat_t              s_data,
    input  logic                  m_valid,
    input  logic                  m_ready,
    input  out_beat_t             m_data,
    input  logic                  cfg_valid,
    input  logic                  cfg_ready,
    input  cfg_idx_t              cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output int                    mismatches,
    output int                    pending
);

    // local copy of the register file
    logic        dz_on;
    logic [14:0] clamp_lim;
    logic [14:0] band_lim;
    logic [15:0] wait_lim;

    // last transmitted pair and its time stamp
    logic [15:0] sent_x;
    logic [15:0] sent_y;
    logic [31:0] sent_t;

    out_beat_t   frac_q[$];
    int          fails;

    function automatic int magnitude(int v);
        return (v < 0) ? -v : v;
    endfunction

    // Q15 rescale outside the deadband; the lower side divides by one more
    function automatic logic [15:0] q15_scale(int v, int band);
        int q;
        q = 0;
        if (v > band) begin
            q = ((v - band) * 32768) / (32767 - band);
            if (q > 32767)
                q = 32767;
        end else if (v < -band) begin
            q = ((-band - v) * 32768) / (32768 - band);
            if (q > 32768)
                q = 32768;
            q = -q;
        end
        return q[15:0];
    endfunction

    function automatic out_beat_t filter_sample(in_beat_t b);
        int          x;
        int          y;
        logic [15:0] fx;
        logic [15:0] fy;
        logic [31:0] elapsed;
        out_beat_t   r;
        r = '0;
        if (!b.connected)
            return r;
        x = $signed(b.stick_x);
        y = $signed(b.stick_y);
        if (dz_on && magnitude(x) <= int'(clamp_lim) && magnitude(y) <= int'(clamp_lim)) begin
            x = 0;
            y = 0;
        end
        fx = q15_scale(x, int'(band_lim));
        fy = q15_scale(y, int'(band_lim));
        elapsed = b.now_ms - sent_t;
        r.send = (elapsed > {16'd0, wait_lim}) || (fx != sent_x) || (fy != sent_y);
        r.frac_x = fx;
        r.frac_y = fy;
        if (r.send) begin
            sent_x = fx;
            sent_y = fy;
            sent_t = b.now_ms;
        end
        return r;
    endfunction

    always @(posedge aclk) begin
        out_beat_t want;
        if (!aresetn) begin
            dz_on = RST_DEADZONE_ENABLE;
            clamp_lim = RST_CLAMP_ZONE;
            band_lim = RST_DEADBAND;
            wait_lim = RST_MAX_WAIT_MS;
            sent_x = '0;
            sent_y = '0;
            sent_t = '0;
            frac_q.delete();
            fails = 0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_DEADZONE_ENABLE: dz_on = cfg_data[0];
                    REG_CLAMP_ZONE:      clamp_lim = cfg_data[14:0];
                    REG_DEADBAND:        band_lim = cfg_data[14:0];
                    REG_MAX_WAIT_MS:     wait_lim = cfg_data;
                    default: ;
                endcase
            end
            if (m_valid && m_ready) begin
                if (frac_q.size() == 0) begin
                    fails++;
                    if (fails <= 10)
                        $display("%0t: result beat with none expected: send=%0b x=%0d y=%0d",
                                 $realtime, m_data.send, m_data.frac_x, m_data.frac_y);
                end else begin
                    want = frac_q.pop_front();
                    if (want.send !== m_data.send || want.frac_x !== m_data.frac_x ||
                        want.frac_y !== m_data.frac_y) begin
                        fails++;
                        // send/frac_x/frac_y
                        if (fails <= 10)
                            $display("%0t: mismatch exp %0b/%0d/%0d got %0b/%0d/%0d",
                                     $realtime, want.send, want.frac_x, want.frac_y,
                                     m_data.send, m_data.frac_x, m_data.frac_y);
                    end
                end
            end
            if (s_valid && s_ready)
                frac_q.push_back(filter_sample(s_data));
        end
        mismatches <= fails;
        pending <= frac_q.size();
    end

endmodule

@@ sim/tb_top.sv @@
module tb_top;
    import sdsf_pkg::*;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    in_beat_t              s_data = '0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    out_beat_t             m_data;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    cfg_idx_t              cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    int                    mismatches;
    int                    pending;

    logic                  quiet = 1'b0;
    logic [14:0]           cur_clamp = RST_CLAMP_ZONE;
    logic [14:0]           cur_band = RST_DEADBAND;
    logic [15:0]           cur_wait = RST_MAX_WAIT_MS;
    logic [31:0]           clock_ms = '0;
    in_beat_t              last_drawn = '0;

    initial begin
        forever #2 aclk = ~aclk;
    end

    stick_deadband_send_filter_unit i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    sdsf_checker i_checker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .mismatches (mismatches),
        .pending    (pending)
    );

    function automatic bit stall_now();
        return !quiet && ($urandom_range(99) < 14);
    endfunction

    always @(posedge aclk) begin
        m_ready <= aresetn && !stall_now();
    end

    function automatic logic [15:0] clip16(int v);
        if (v > 32767)
            v = 32767;
        if (v < -32768)
            v = -32768;
        return v[15:0];
    endfunction

    function automatic in_beat_t mk(int x, int y, bit conn, logic [31:0] t);
        in_beat_t b;
        b.stick_x = x[15:0];
        b.stick_y = y[15:0];
        b.connected = conn;
        b.now_ms = t;
        return b;
    endfunction

    function automatic logic [15:0] pick_axis(int prev);
        int v;
        int m;
        v = prev;
        case ($urandom_range(7))
            0, 1: v = int'($urandom_range(65535)) - 32768;
            2: v = int'($urandom_range(2 * int'(cur_clamp))) - int'(cur_clamp);
            3: begin
                m = int'(cur_clamp) + int'($urandom_range(2)) - 1;
                v = $urandom_range(1) ? m : -m;
            end
            4: begin
                m = int'(cur_band) + int'($urandom_range(2)) - 1;
                v = $urandom_range(1) ? m : -m;
            end
            5: begin
                case ($urandom_range(4))
                    0: v = -32768;
                    1: v = 32767;
                    2: v = 0;
                    3: v = -1;
                    default: v = 1;
                endcase
            end
            default: ;
        endcase
        return clip16(v);
    endfunction

    // repeated pairs and short time steps keep the send-on-change path busy
    function automatic in_beat_t draw_sample();
        in_beat_t b;
        b = last_drawn;
        if ($urandom_range(99) >= 35) begin
            b.stick_x = pick_axis($signed(last_drawn.stick_x));
            b.stick_y = pick_axis($signed(last_drawn.stick_y));
        end
        b.connected = ($urandom_range(99) >= 10);
        case ($urandom_range(9))
            0: clock_ms = $urandom;
            1: clock_ms = clock_ms + cur_wait;
            2: clock_ms = clock_ms + cur_wait + 1;
            3: ;
            default: clock_ms = clock_ms + $urandom_range(40);
        endcase
        b.now_ms = clock_ms;
        last_drawn = b;
        return b;
    endfunction

    task automatic offer_sample(in_beat_t b);
        if (stall_now()) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 40)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= b;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0)
            @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic set_regs(logic en, logic [14:0] cz, logic [14:0] band, logic [15:0] mw);
        cfg_idx_t              idx [4];
        logic [CFG_DATA_W-1:0] val [4];
        idx = '{REG_DEADZONE_ENABLE, REG_CLAMP_ZONE, REG_DEADBAND, REG_MAX_WAIT_MS};
        val = '{{15'd0, en}, {1'b0, cz}, {1'b0, band}, mw};
        cur_clamp = cz;
        cur_band = band;
        cur_wait = mw;
        cfg_valid <= 1'b1;
        for (int i = 0; i < 4; i++) begin
            cfg_index <= idx[i];
            cfg_data <= val[i];
            do @(posedge aclk); while (!cfg_ready);
        end
        cfg_valid <= 1'b0;
    endtask

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset settings: zero pair, full scale, clamp edges, disconnect, time wrap
        offer_sample(mk(0, 0, 1, 32'd0));
        offer_sample(mk(32767, -32768, 1, 32'd10));
        offer_sample(mk(32767, -32768, 1, 32'd20));
        offer_sample(mk(32767, -32768, 1, 32'd521));
        offer_sample(mk(7864, -7864, 1, 32'd530));
        offer_sample(mk(7865, 0, 1, 32'd540));
        offer_sample(mk(-7865, 7864, 1, 32'd550));
        offer_sample(mk(6001, -6001, 1, 32'd560));
        offer_sample(mk(-32768, 32767, 0, 32'hFFFF_FFFF));
        offer_sample(mk(0, 0, 1, 32'hFFFF_FFF0));
        offer_sample(mk(0, 0, 1, 32'h0000_0010));
        offer_sample(mk(0, 0, 1, 32'h0000_0300));

        drain();
        set_regs(1'b0, 15'd0, 15'd0, 16'd0);
        offer_sample(mk(1, -1, 1, 32'd100));
        offer_sample(mk(32767, -32768, 1, 32'd100));
        offer_sample(mk(-32768, 32767, 1, 32'd100));
        offer_sample(mk(0, 0, 1, 32'd100));
        offer_sample(mk(0, 0, 1, 32'd100));
        offer_sample(mk(0, 0, 1, 32'd101));

        // deadband at its 15-bit top: only the lower side can move
        drain();
        set_regs(1'b0, 15'h7FFF, 15'h7FFF, 16'hFFFF);
        offer_sample(mk(32767, -32768, 1, 32'd5));
        offer_sample(mk(-32767, -32768, 1, 32'd6));
        offer_sample(mk(32767, -32768, 1, 32'd7));

        drain();
        set_regs(1'b1, 15'h7FFF, 15'd32766, 16'hFFFF);
        offer_sample(mk(32767, -32768, 1, 32'd0));
        offer_sample(mk(-32767, 32767, 1, 32'd1));

        for (int phase = 0; phase < 7; phase++) begin
            drain();
            case (phase)
                0: set_regs(RST_DEADZONE_ENABLE, RST_CLAMP_ZONE, RST_DEADBAND, RST_MAX_WAIT_MS);
                1: set_regs(1'b0, 15'd0, 15'd0, 16'd0);
                2: set_regs(1'b1, 15'h7FFF, 15'd32766, 16'hFFFF);
                4: set_regs(1'b0, 15'($urandom_range(32767)), 15'h7FFF,
                            16'($urandom_range(1000)));
                default: set_regs(1'($urandom_range(1)), 15'($urandom_range(32767)),
                                  15'($urandom_range(32766)),
                                  $urandom_range(1) ? 16'($urandom_range(65535))
                                                    : 16'($urandom_range(100)));
            endcase
            quiet <= (phase == 3);
            repeat (100) offer_sample(draw_sample());
        end

        drain();
        repeat (20) @(posedge aclk);
        if (mismatches == 0 && pending == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

    initial begin
        #2000000;
        $display("tb_top failed");
        $finish;
    end

endmodule

@@ files.f @@
sv/sdsf_pkg.sv
sv/sdsf_ctrl.sv
sv/sdsf_dp.sv
sv/stick_deadband_send_filter_unit.sv
sim/sdsf_checker.sv
sim/tb_top.sv
